FILE: sv/wtosc_pkg.sv
// wtosc_pkg: shared types, constants and the quarter-wave sine table for the
// wavetable oscillator. Depends on nothing.

package wtosc_pkg;

  localparam int TABLE_POINTS        = 256;
  localparam int INDEX_BITS          = $clog2(TABLE_POINTS);
  localparam int PHASE_FRACTION_BITS = 16;
  localparam int PHASE_BITS          = INDEX_BITS + PHASE_FRACTION_BITS;
  localparam int SAMPLE_BITS         = 16;
  localparam int WIDE_BITS           = SAMPLE_BITS + 4;
  localparam int CFG_INDEX_BITS      = 2;
  localparam int CFG_DATA_BITS       = 24;
  localparam int SEL_BITS            = 2;

  localparam int  QUARTER_POINTS = TABLE_POINTS / 4;
  localparam int  QUARTER_BITS   = INDEX_BITS - 2;
  localparam longint FULL_SCALE  = longint'(1) << (SAMPLE_BITS - 1);
  localparam int  TRI_STEP       = 4 * (1 << (SAMPLE_BITS - 1)) / TABLE_POINTS;
  localparam int  SAW_STEP       = 2 * (1 << (SAMPLE_BITS - 1)) / TABLE_POINTS;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM_SELECT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = 2'd1;

  typedef enum logic [SEL_BITS-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_PULSE    = 2'd3
  } wave_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    wave_t                 wave;
  } phase_item_t;

  typedef logic [QUARTER_POINTS:0][SAMPLE_BITS-1:0] quarter_table_t;
  typedef logic [7:0][8:0] taylor_div_t;

  localparam taylor_div_t TAYLOR_DIV = {9'd272, 9'd210, 9'd156, 9'd110,
                                        9'd72, 9'd42, 9'd20, 9'd6};

  function automatic logic signed [SAMPLE_BITS-1:0] saturate(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = WIDE_BITS'(FULL_SCALE - 1);
    lo = -WIDE_BITS'(FULL_SCALE);
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  // evaluated at elaboration: sine magnitude at each point of the first quadrant
  function automatic quarter_table_t build_quarter_sine();
    quarter_table_t tbl;
    logic [63:0]    k;
    logic [63:0]    x;
    logic [63:0]    x2;
    logic [63:0]    term;
    logic [63:0]    mag;
    longint         sum;
    for (int j = 0; j <= QUARTER_POINTS; j++) begin
      k    = 64'(4 * j);
      x    = (HALF_PI_Q30 * k + 64'(TABLE_POINTS / 2)) / 64'(TABLE_POINTS);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int m = 1; m <= 8; m++) begin
        term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[m-1]);
        if (m % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      mag = (64'(sum) * 64'(FULL_SCALE) + (64'd1 << 29)) >> 30;
      if (mag > 64'(FULL_SCALE - 1)) begin
        mag = 64'(FULL_SCALE - 1);
      end
      tbl[j] = mag[SAMPLE_BITS-1:0];
    end
    return tbl;
  endfunction

  localparam quarter_table_t QUARTER_SINE = build_quarter_sine();

endpackage

FILE: sv/wtosc_phase.sv
// wtosc_phase: configuration registers and the phase accumulator.
// Uses wtosc_pkg.

module wtosc_phase (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [wtosc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [wtosc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                   advance,
  output wtosc_pkg::phase_item_t                 item
);

  wtosc_pkg::wave_t                      waveform_select;
  logic [wtosc_pkg::PHASE_BITS-1:0]      phase_increment;
  logic [wtosc_pkg::PHASE_BITS-1:0]      phase_accumulator;
  logic [wtosc_pkg::PHASE_BITS-1:0]      phase_accumulator_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform_select <= wtosc_pkg::WAVE_SINE;
      phase_increment <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        wtosc_pkg::REG_WAVEFORM_SELECT: begin
          waveform_select <= wtosc_pkg::wave_t'(cfg_data[wtosc_pkg::SEL_BITS-1:0]);
        end
        wtosc_pkg::REG_PHASE_INCREMENT: begin
          phase_increment <= cfg_data[wtosc_pkg::PHASE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // natural wrap at the table span
  assign phase_accumulator_next = phase_accumulator + phase_increment;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_accumulator <= '0;
    end else if (advance) begin
      phase_accumulator <= phase_accumulator_next;
    end
  end

  assign item.index = phase_accumulator[wtosc_pkg::PHASE_BITS-1:wtosc_pkg::PHASE_FRACTION_BITS];
  assign item.wave  = waveform_select;

endmodule

FILE: sv/wtosc_shape.sv
// wtosc_shape: waveform value at one table index, sine from the quarter-wave
// table and the other shapes computed. Uses wtosc_pkg.

module wtosc_shape (
  input  wtosc_pkg::phase_item_t                  item,
  output logic signed [wtosc_pkg::SAMPLE_BITS-1:0] sample
);

  localparam int IB = wtosc_pkg::INDEX_BITS;
  localparam int WB = wtosc_pkg::WIDE_BITS;
  localparam int QB = wtosc_pkg::QUARTER_BITS;

  logic [1:0]                          quadrant;
  logic [QB-1:0]                       offset;
  logic [QB:0]                         qidx;
  logic signed [WB-1:0]                sine_mag;
  logic signed [WB-1:0]                iw;
  logic signed [WB-1:0]                wide;

  assign quadrant = item.index[IB-1:IB-2];
  assign offset   = item.index[QB-1:0];
  assign qidx     = quadrant[0] ? (QB+1)'(wtosc_pkg::QUARTER_POINTS) - {1'b0, offset}
                                : {1'b0, offset};
  assign sine_mag = WB'(wtosc_pkg::QUARTER_SINE[qidx]);
  assign iw       = WB'(item.index);

  always_comb begin
    case (item.wave)
      wtosc_pkg::WAVE_SINE: begin
        wide = quadrant[1] ? -sine_mag : sine_mag;
      end
      wtosc_pkg::WAVE_TRIANGLE: begin
        if (item.index < IB'(wtosc_pkg::TABLE_POINTS / 4)) begin
          wide = iw * WB'(wtosc_pkg::TRI_STEP);
        end else if (item.index < IB'(wtosc_pkg::TABLE_POINTS * 3 / 4)) begin
          wide = WB'(2 * wtosc_pkg::FULL_SCALE) - iw * WB'(wtosc_pkg::TRI_STEP);
        end else begin
          wide = iw * WB'(wtosc_pkg::TRI_STEP) - WB'(3 * wtosc_pkg::FULL_SCALE);
        end
      end
      wtosc_pkg::WAVE_SAW: begin
        wide = WB'(wtosc_pkg::FULL_SCALE) - iw * WB'(wtosc_pkg::SAW_STEP);
      end
      wtosc_pkg::WAVE_PULSE: begin
        wide = (item.index < IB'(wtosc_pkg::TABLE_POINTS / 2))
             ? WB'(wtosc_pkg::FULL_SCALE - 1) : -WB'(wtosc_pkg::FULL_SCALE);
      end
      default: begin
        wide = '0;
      end
    endcase
  end

  assign sample = wtosc_pkg::saturate(wide);

endmodule

FILE: sv/wavetable_oscillator.sv
// wavetable_oscillator: top level of the stereo wavetable oscillator.
// Uses wtosc_pkg, wtosc_phase and wtosc_shape.

// Each accepted tick item with sample_tick set yields one stereo frame that
// passes two registers (phase/index register loaded at the accepting edge, then
// the output register) on its way to the output, and a new tick is taken every
// cycle while the output side keeps up; the rate is set by the 24-bit phase
// accumulator. The frame is read at the phase held before the tick; the phase
// then advances by phase_increment and wraps at the full table span. A tick
// item with sample_tick clear produces no frame and leaves the phase where it
// is. Left and right are always equal. Configuration writes are taken at any
// time and apply to ticks accepted after.

module wavetable_oscillator (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_write,
  input  logic [wtosc_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [wtosc_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic                                      sample_tick,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [wtosc_pkg::SAMPLE_BITS-1:0]  left_sample,
  output logic signed [wtosc_pkg::SAMPLE_BITS-1:0]  right_sample
);

  wtosc_pkg::phase_item_t                    cur_item;
  wtosc_pkg::phase_item_t                    stage_item;
  logic                                      stage_valid;
  logic                                      out_load;
  logic                                      stage_load;
  logic                                      tick_accept;
  logic signed [wtosc_pkg::SAMPLE_BITS-1:0]  shape_sample;

  assign out_load    = !out_valid || !out_stall;
  assign in_stall    = stage_valid && !out_load;
  assign stage_load  = !in_stall;
  assign tick_accept = in_valid && !in_stall && sample_tick;

  wtosc_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (tick_accept),
    .item      (cur_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_load) begin
      stage_valid <= tick_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      stage_item <= cur_item;
    end
  end

  wtosc_shape u_shape (
    .item   (stage_item),
    .sample (shape_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && stage_valid) begin
      left_sample  <= shape_sample;
      right_sample <= shape_sample;
    end
  end

endmodule

FILE: sv/wtosc_checker.sv
// wtosc_checker: port-level assertions for wavetable_oscillator, bound to the
// top level. Uses wtosc_pkg.

module wtosc_checker (
  input logic                                      clk,
  input logic                                      rst,
  input logic                                      in_valid,
  input logic                                      in_stall,
  input logic                                      sample_tick,
  input logic                                      out_valid,
  input logic                                      out_stall,
  input logic signed [wtosc_pkg::SAMPLE_BITS-1:0]  left_sample,
  input logic signed [wtosc_pkg::SAMPLE_BITS-1:0]  right_sample
);

  // held frame stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(left_sample))
    else $error("stalled frame changed");

  a_channels_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> left_sample == right_sample)
    else $error("left and right differ");

  // empty output never back-pressures the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // a tick reaches the output through the stage and output registers when not stalled
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && sample_tick) ##1 !out_stall |=> out_valid)
    else $error("frame missing after tick");

endmodule

bind wavetable_oscillator wtosc_checker u_wtosc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .sample_tick  (sample_tick),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .left_sample  (left_sample),
  .right_sample (right_sample)
);
